### sv/dspo_pkg.sv
// shared constants, field widths and inter-stage types for the dna overlap block
// no dependencies
package dspo_pkg;

   // longest string the block handles, in nucleotides
   localparam int MAX_SYMBOLS = 32;

   // fixed field widths of the request and response items
   localparam int SEQ_W = 64;
   localparam int LEN_W = 6;

   // internal widths
   localparam int SYM_W = 2 * MAX_SYMBOLS;
   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

   // request tdata layout, lowest field first
   localparam int FIRST_SEQ_LO  = 0;
   localparam int FIRST_LEN_LO  = FIRST_SEQ_LO + SEQ_W;
   localparam int SECOND_SEQ_LO = FIRST_LEN_LO + LEN_W;
   localparam int SECOND_LEN_LO = SECOND_SEQ_LO + SEQ_W;
   localparam int REQ_USED_W    = SECOND_LEN_LO + LEN_W;
   localparam int REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata layout
   localparam int RSP_DATA_W = ((LEN_W + 7) / 8) * 8;

   // aligned operands handed from the input stage to the lanes
   typedef struct packed {
      logic [SYM_W-1:0] first;       // first string, last symbol in bits 1:0
      logic [SYM_W-1:0] second_top;  // second string, first symbol at the top
      logic [CNT_W-1:0] span;        // shorter of the two clamped lengths
   } align_type;

   // one match flag per candidate overlap length
   typedef logic [MAX_SYMBOLS:1] match_type;

endpackage

### sv/dspo_align.sv
// input stage: clamps both lengths and left-aligns the second string
// depends on dspo_pkg
module dspo_align (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [dspo_pkg::SEQ_W-1:0]  first_seq,
   input  logic [dspo_pkg::LEN_W-1:0]  first_len,
   input  logic [dspo_pkg::SEQ_W-1:0]  second_seq,
   input  logic [dspo_pkg::LEN_W-1:0]  second_len,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dspo_pkg::align_type         out_data
);

   logic                        valid_ff;
   logic                        valid_in;
   dspo_pkg::align_type         data_ff;
   dspo_pkg::align_type         data_in;
   logic [dspo_pkg::CNT_W-1:0]  na;
   logic [dspo_pkg::CNT_W-1:0]  nb;
   logic [dspo_pkg::CNT_W:0]    shift;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      // lengths above the limit saturate
      if (first_len > dspo_pkg::LEN_W'(dspo_pkg::MAX_SYMBOLS)) begin
         na = dspo_pkg::CNT_W'(dspo_pkg::MAX_SYMBOLS);
      end else begin
         na = first_len[dspo_pkg::CNT_W-1:0];
      end
      if (second_len > dspo_pkg::LEN_W'(dspo_pkg::MAX_SYMBOLS)) begin
         nb = dspo_pkg::CNT_W'(dspo_pkg::MAX_SYMBOLS);
      end else begin
         nb = second_len[dspo_pkg::CNT_W-1:0];
      end
      // pushing the second string to the top drops its stray high bits
      shift = {dspo_pkg::CNT_W'(dspo_pkg::MAX_SYMBOLS) - nb, 1'b0};
      data_in.first      = first_seq[dspo_pkg::SYM_W-1:0];
      data_in.second_top = second_seq[dspo_pkg::SYM_W-1:0] << shift;
      data_in.span       = (na < nb) ? na : nb;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

### sv/dspo_lanes.sv
// compare lanes: one lane per candidate overlap length, all in parallel
// depends on dspo_pkg
module dspo_lanes (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  dspo_pkg::align_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output dspo_pkg::match_type  out_match
);

   logic                 valid_ff;
   logic                 valid_in;
   dspo_pkg::match_type  match_ff;
   dspo_pkg::match_type  match_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_match = match_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   // lane k: last k symbols of first against first k symbols of second
   for (genvar k = 1; k <= dspo_pkg::MAX_SYMBOLS; k++) begin : g_lane
      assign match_in[k] =
         (in_data.first[2*k-1:0] ==
          in_data.second_top[dspo_pkg::SYM_W-1:dspo_pkg::SYM_W-2*k]) &&
         (dspo_pkg::CNT_W'(k) <= in_data.span);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         match_ff <= match_in;
      end
   end

endmodule

### sv/dspo_merge.sv
// merge stage: picks the longest matching lane and holds the response item
// depends on dspo_pkg
module dspo_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  dspo_pkg::match_type              in_match,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dspo_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [dspo_pkg::CNT_W-1:0]  best_ff;
   logic [dspo_pkg::CNT_W-1:0]  best_in;

   assign in_ready   = !valid_ff || rsp_tready;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = dspo_pkg::RSP_DATA_W'(best_ff);

   // highest set lane wins, none set gives zero
   always_comb begin
      best_in = '0;
      for (int k = 1; k <= dspo_pkg::MAX_SYMBOLS; k++) begin
         if (in_match[k]) begin
            best_in = dspo_pkg::CNT_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         best_ff <= best_in;
      end
   end

endmodule

### sv/dna_suffix_prefix_overlap.sv
// top level of the dna suffix/prefix overlap block
// depends on dspo_pkg, dspo_align, dspo_lanes, dspo_merge
//
//   channel  dir  bits  contents (lowest bit first)
//   req_*    in   144   first_seq[63:0] first_len[69:64] second_seq[133:70]
//                       second_len[139:134], zero pad [143:140]
//   rsp_*    out  8     overlap_len[5:0], zero pad [7:6]
//
// an item passes the align register, the lane compare register and the merge
// register in turn; its response item shows on rsp_tvalid once the merge
// register holds it
// with no backpressure a new item is taken every cycle; the three stages
// each hold one item and a bubble in any stage is filled at once
// a stalled response holds its stage and backs up the ones before it;
// req_tready drops only once all three stages are full
// reset is synchronous and empties every stage; payload is not cleared
module dna_suffix_prefix_overlap (
   input  logic                             clock,
   input  logic                             reset,
   // request items
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // first_seq, first_len, second_seq, second_len, pad
   input  logic [dspo_pkg::REQ_DATA_W-1:0]  req_tdata,
   // response items
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // overlap_len, pad
   output logic [dspo_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // unpacked request fields
   logic [dspo_pkg::SEQ_W-1:0]  first_seq;
   logic [dspo_pkg::LEN_W-1:0]  first_len;
   logic [dspo_pkg::SEQ_W-1:0]  second_seq;
   logic [dspo_pkg::LEN_W-1:0]  second_len;

   // stage links
   logic                 align_valid;
   logic                 align_ready;
   dspo_pkg::align_type  align_data;
   logic                 lane_valid;
   logic                 lane_ready;
   dspo_pkg::match_type  lane_match;

   assign first_seq  = req_tdata[dspo_pkg::FIRST_SEQ_LO +: dspo_pkg::SEQ_W];
   assign first_len  = req_tdata[dspo_pkg::FIRST_LEN_LO +: dspo_pkg::LEN_W];
   assign second_seq = req_tdata[dspo_pkg::SECOND_SEQ_LO +: dspo_pkg::SEQ_W];
   assign second_len = req_tdata[dspo_pkg::SECOND_LEN_LO +: dspo_pkg::LEN_W];

   // clamp lengths, take the shorter one and put the second string's
   // first symbol at the top so each lane reads a fixed slice
   dspo_align u_align (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .first_seq  (first_seq),
      .first_len  (first_len),
      .second_seq (second_seq),
      .second_len (second_len),
      .out_valid  (align_valid),
      .out_ready  (align_ready),
      .out_data   (align_data)
   );

   // one equality lane per candidate length, gated by the shorter length
   dspo_lanes u_lanes (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (align_valid),
      .in_ready  (align_ready),
      .in_data   (align_data),
      .out_valid (lane_valid),
      .out_ready (lane_ready),
      .out_match (lane_match)
   );

   // longest matching lane becomes the response
   dspo_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (lane_valid),
      .in_ready   (lane_ready),
      .in_match   (lane_match),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### sv/dspo_checker.sv
// port-level checks for the dna overlap block, bound to its top level
// depends on dspo_pkg and dna_suffix_prefix_overlap
module dspo_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dspo_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // nothing left in flight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // the pipeline only pushes back when the response is stuck
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request stalled without a stalled response");

   // overlap never exceeds the longest string the block handles
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= dspo_pkg::RSP_DATA_W'(dspo_pkg::MAX_SYMBOLS)))
      else $error("overlap length out of range");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind dna_suffix_prefix_overlap dspo_checker u_dspo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/dspo_overlap_checker.sv
`timescale 1ns / 100ps
// watches both streams of the dna overlap block, predicts each overlap length and compares
// depends on dspo_pkg
module dspo_overlap_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [dspo_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [dspo_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output int                               fail_count,
   output int                               pending
);

   logic [dspo_pkg::LEN_W-1:0] expected_overlap[$];
   int mismatches = 0;

   // longest suffix of the first string that is a prefix of the second
   function automatic logic [dspo_pkg::LEN_W-1:0] overlap_of(
         logic [dspo_pkg::SEQ_W-1:0] first_seq,
         logic [dspo_pkg::LEN_W-1:0] first_len,
         logic [dspo_pkg::SEQ_W-1:0] second_seq,
         logic [dspo_pkg::LEN_W-1:0] second_len);
      int na;
      int nb;
      int span;
      logic [dspo_pkg::SEQ_W-1:0] tail;
      logic [dspo_pkg::SEQ_W-1:0] head;
      logic [dspo_pkg::LEN_W-1:0] found;
      na = (first_len > dspo_pkg::MAX_SYMBOLS) ? dspo_pkg::MAX_SYMBOLS : first_len;
      nb = (second_len > dspo_pkg::MAX_SYMBOLS) ? dspo_pkg::MAX_SYMBOLS : second_len;
      span = (na < nb) ? na : nb;
      found = '0;
      second_seq &= ~64'd0 >> (64 - 2 * nb);
      for (int n = span; n > 0; n--) begin
         tail = first_seq & (~64'd0 >> (64 - 2 * n));
         head = second_seq >> (2 * (nb - n));
         if (tail == head && found == '0) begin
            found = dspo_pkg::LEN_W'(n);
         end
      end
      return found;
   endfunction

   always @(posedge clock) begin
      logic [dspo_pkg::LEN_W-1:0] want;
      logic [dspo_pkg::LEN_W-1:0] got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_overlap = {expected_overlap,
               overlap_of(req_tdata[dspo_pkg::FIRST_SEQ_LO +: dspo_pkg::SEQ_W],
                          req_tdata[dspo_pkg::FIRST_LEN_LO +: dspo_pkg::LEN_W],
                          req_tdata[dspo_pkg::SECOND_SEQ_LO +: dspo_pkg::SEQ_W],
                          req_tdata[dspo_pkg::SECOND_LEN_LO +: dspo_pkg::LEN_W])};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[dspo_pkg::LEN_W-1:0];
            if (expected_overlap.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual overlap_len %0d",
                        $time, got);
               mismatches++;
            end else begin
               want = expected_overlap.pop_front();
               if (got !== want) begin
                  $display("%0t: overlap_len mismatch, expected %0d, actual %0d",
                           $time, want, got);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      pending <= expected_overlap.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// top of the dna overlap testbench: clock, reset, request and response traffic, verdict
// depends on dspo_pkg, dna_suffix_prefix_overlap and dspo_overlap_checker
module tb;

   localparam int RANDOM_PAIRS = 480;
   // response hold-off long enough to fill all three stages and stall the input
   localparam int HOLD_OFF = 80;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [dspo_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [dspo_pkg::RSP_DATA_W-1:0] rsp_tdata;
   int                              fail_count;
   int                              pending;
   int                              sent = 0;
   int                              taken = 0;

   dna_suffix_prefix_overlap DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dspo_overlap_checker u_overlap_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // single synchronous reset at the start of the run
   initial begin
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #(200_000);
      $display("** dna_suffix_prefix_overlap: FAILED **");
      $finish;
   end

   // length field: mostly legal, sometimes zero, sometimes above the limit (saturates)
   function automatic logic [dspo_pkg::LEN_W-1:0] draw_len();
      int pick;
      pick = $urandom_range(0, 31);
      if (pick == 0) begin
         return '0;
      end
      if (pick < 3) begin
         return dspo_pkg::LEN_W'($urandom_range(33, 63));
      end
      return dspo_pkg::LEN_W'($urandom_range(1, 32));
   endfunction

   // second string of eb symbols whose first `overlap` symbols repeat the last ones
   // of the first string; low_fill pads the rest, high_fill lands above the length
   function automatic logic [dspo_pkg::SEQ_W-1:0] link_second(
         logic [dspo_pkg::SEQ_W-1:0] first_seq, int eb, int overlap,
         logic [dspo_pkg::SEQ_W-1:0] low_fill,
         logic [dspo_pkg::SEQ_W-1:0] high_fill);
      logic [dspo_pkg::SEQ_W-1:0] shared;
      shared = first_seq & (~64'd0 >> (64 - 2 * overlap));
      return (shared << (2 * (eb - overlap)))
           | (low_fill & (~64'd0 >> (64 - 2 * (eb - overlap))))
           | (high_fill & ~(~64'd0 >> (64 - 2 * eb)));
   endfunction

   // offer one item; valid stays high across back-to-back items
   task automatic offer_pair(input logic [dspo_pkg::SEQ_W-1:0] first_seq,
                             input logic [dspo_pkg::LEN_W-1:0] first_len,
                             input logic [dspo_pkg::SEQ_W-1:0] second_seq,
                             input logic [dspo_pkg::LEN_W-1:0] second_len);
      int gap;
      // every third stretch of 40 items goes with no gaps at all
      gap = ((sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(dspo_pkg::REQ_DATA_W - dspo_pkg::REQ_USED_W){1'b0}},
                    second_len, second_seq, first_len, first_seq};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // well-formed pair with a planted overlap and random content
   task automatic offer_linked();
      logic [dspo_pkg::LEN_W-1:0] fl;
      logic [dspo_pkg::LEN_W-1:0] sl;
      logic [dspo_pkg::SEQ_W-1:0] fs;
      logic [dspo_pkg::SEQ_W-1:0] ss;
      int ea;
      int eb;
      int overlap;
      fl = draw_len();
      sl = draw_len();
      ea = (fl > dspo_pkg::MAX_SYMBOLS) ? dspo_pkg::MAX_SYMBOLS : fl;
      eb = (sl > dspo_pkg::MAX_SYMBOLS) ? dspo_pkg::MAX_SYMBOLS : sl;
      overlap = $urandom_range(0, (ea < eb) ? ea : eb);
      fs = {$urandom, $urandom};
      // half the time the first string carries no stray bits above its length
      if ($urandom_range(0, 1) == 1) begin
         fs &= ~64'd0 >> (64 - 2 * ea);
      end
      ss = link_second(fs, eb, overlap, {$urandom, $urandom},
                       ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : 64'd0);
      offer_pair(fs, fl, ss, sl);
   endtask

   // unrelated pair; homopolymers now and then to give long chance overlaps
   task automatic offer_noise();
      logic [1:0] base_a;
      logic [1:0] base_b;
      base_a = 2'($urandom);
      base_b = 2'($urandom);
      if ($urandom_range(0, 2) == 0) begin
         offer_pair({32{base_a}}, draw_len(), {32{base_b}}, draw_len());
      end else begin
         offer_pair({$urandom, $urandom}, draw_len(), {$urandom, $urandom}, draw_len());
      end
   endtask

   // request side: directed corners, then random pairs, then drain and verdict
   initial begin
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // zero lengths on either or both sides
      offer_pair(64'd0, 6'd0, 64'd0, 6'd0);
      offer_pair(~64'd0, 6'd32, ~64'd0, 6'd0);
      offer_pair(~64'd0, 6'd0, ~64'd0, 6'd5);
      // full-length identical strings, all A and all T
      offer_pair(64'd0, 6'd32, 64'd0, 6'd32);
      offer_pair(~64'd0, 6'd32, ~64'd0, 6'd32);
      // lengths above the limit saturate to 32
      offer_pair(~64'd0, 6'd63, ~64'd0, 6'd63);
      offer_pair(64'h0123_4567_89ab_cdef, 6'd33, 64'h0123_4567_89ab_cdef, 6'd40);
      // single symbols: each base against itself, then a miss
      offer_pair(64'h0, 6'd1, 64'h0, 6'd1);
      offer_pair(64'h1, 6'd1, 64'h1, 6'd1);
      offer_pair(64'h2, 6'd1, 64'h2, 6'd1);
      offer_pair(64'h3, 6'd1, 64'h3, 6'd1);
      offer_pair(64'h0, 6'd1, 64'h1, 6'd1);
      // no overlap at all: all A against all T
      offer_pair(64'd0, 6'd10, ~64'd0, 6'd10);
      // overlap of exactly one: ...G against G then C's
      offer_pair(64'h0000_0000_0000_0006, 6'd2, 64'h0000_0000_0000_0095, 6'd4);
      // stray high bits above both lengths must be dropped
      offer_pair(64'hffff_ffff_ffff_ff1b, 6'd4, 64'ha5a5_a5a5_a5a5_a51b, 6'd4);
      offer_pair(64'hdead_beef_0000_001b, 6'd4, 64'h5555_5555_5555_5500, 6'd4);
      // equal-length k-mer overlap, ACGTACGT then GTACGTAA
      offer_pair(64'h0000_0000_0000_1b1b, 6'd8, 64'h0000_0000_0000_b1b0, 6'd8);
      // shorter first string fully contained as prefix of a long second
      offer_pair(64'h0000_0000_0000_0027, 6'd3,
                 link_second(64'h27, 20, 3, 64'h1234_5678_9abc_def0, 64'd0), 6'd20);
      // longest string on one side only, both orders
      offer_pair(64'hfedc_ba98_7654_3210, 6'd32,
                 link_second(64'hfedc_ba98_7654_3210, 7, 7, 64'd0, ~64'd0), 6'd7);
      offer_pair(64'h0000_0000_0000_2d4b, 6'd7,
                 link_second(64'h2d4b, 32, 7, 64'h0f0f_f0f0_3c3c_c3c3, 64'd0), 6'd32);

      // random part: mostly planted overlaps, the rest unrelated pairs
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            offer_linked();
         end else begin
            offer_noise();
         end
      end
      req_tvalid <= 1'b0;

      // let the last item reach the checker's count, then drain
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** dna_suffix_prefix_overlap: PASSED **");
      end else begin
         $display("** dna_suffix_prefix_overlap: FAILED **");
      end
      $finish;
   end

   // response side: random stalls per item, calm stretches, and two long hold-offs
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == 150 || taken == 350) begin
            stall = HOLD_OFF;
         end else if ((taken / 50) % 3 == 2) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

endmodule
